/* rtl/core/mrf_pkg.sv */
`default_nettype none

package mrf_pkg;

  // Bytes in one output report, report id included.
  localparam int REPORT_BYTES = 20;
  localparam int SLOT_W       = $clog2(REPORT_BYTES);

  localparam int LIMIT_W = 12;
  localparam int LEN_W   = 16;
  localparam int TOTAL_W = LIMIT_W + 1;
  localparam int CI_W    = 4;

  // Index of the message byte in a frame's content sequence; 0..13 are header.
  localparam logic [CI_W-1:0] CI_DATA = CI_W'(14);

  localparam logic [15:0] CODE_SINGLE = 16'hC0FF;
  localparam logic [15:0] CODE_FIRST  = 16'h4000;
  localparam logic [15:0] CODE_LAST   = 16'h80FF;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RPT_TAG     = CFG_IDX_W'(1);

  localparam logic [LIMIT_W-1:0] CHUNK_LIMIT_RST = LIMIT_W'(248);
  localparam logic [7:0]         RPT_TAG_RST     = 8'h0E;

  // One classified message byte, handed from the front end to the emitter.
  typedef struct packed {
    logic [7:0]         data;
    logic               hdr;     // a frame header goes out before the data byte
    logic [TOTAL_W-1:0] total;   // frame length field: chunk bytes plus 2
    logic [15:0]        code;    // framing code
    logic               pad;     // the frame closes with this byte
    logic               mend;    // last byte of the message
  } mrf_entry_t;

  function automatic logic [7:0] content_byte(input logic [CI_W-1:0] ci,
                                              input mrf_entry_t e);
    logic [7:0] b;
    case (ci)
      4'd0:    b = 8'h73;
      4'd1:    b = 8'h79;
      4'd2:    b = 8'h6E;
      4'd3:    b = 8'h61;
      4'd4:    b = 8'h70;
      4'd5:    b = 8'h74;
      4'd6:    b = 8'h69;
      4'd7:    b = 8'h63;
      4'd8:    b = e.total[7:0];
      4'd9:    b = 8'(e.total[TOTAL_W-1:8]);
      4'd12:   b = e.code[7:0];
      4'd13:   b = e.code[15:8];
      4'd14:   b = e.data;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/mrf_front.sv */
`default_nettype none

module mrf_front
  import mrf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [LIMIT_W-1:0] chunk_limit_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         message_byte_i,
  input  wire logic [LEN_W-1:0]   message_length_i,
  output logic                    push_o,
  output mrf_entry_t              entry_o,
  input  wire logic               push_ready_i
);

  logic [LEN_W-1:0]   bytes_left_q, bytes_left_d;
  logic               multi_q, multi_d;
  logic [LEN_W-1:0]   frame_index_q, frame_index_d;
  logic [LIMIT_W-1:0] chunk_left_q, chunk_left_d;

  logic               accept, start, drop, new_frame, bl_fits;
  logic [LIMIT_W-1:0] limit, chunk, cl_eff;
  logic [LEN_W-1:0]   bl_eff, fi_eff;
  logic [15:0]        code;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign start      = (bytes_left_q == '0);
  assign drop       = start && (message_length_i == '0);

  always_comb begin
    limit     = (chunk_limit_i == '0) ? LIMIT_W'(1) : chunk_limit_i;
    bl_eff    = start ? message_length_i : bytes_left_q;
    fi_eff    = start ? '0 : frame_index_q;
    cl_eff    = start ? '0 : chunk_left_q;
    multi_d   = start ? (message_length_i > LEN_W'(limit)) : multi_q;
    bl_fits   = (bl_eff <= LEN_W'(limit));
    chunk     = bl_fits ? bl_eff[LIMIT_W-1:0] : limit;
    new_frame = (cl_eff == '0);

    if (!multi_d) begin
      code = CODE_SINGLE;
    end else if (fi_eff == '0) begin
      code = CODE_FIRST;
    end else if (bl_fits) begin
      code = CODE_LAST;
    end else begin
      code = fi_eff;
    end

    chunk_left_d  = (new_frame ? chunk : cl_eff) - LIMIT_W'(1);
    bytes_left_d  = bl_eff - LEN_W'(1);
    frame_index_d = new_frame ? fi_eff + LEN_W'(1) : fi_eff;

    entry_o.data  = message_byte_i;
    entry_o.hdr   = new_frame;
    entry_o.total = {1'b0, chunk} + TOTAL_W'(2);
    entry_o.code  = code;
    entry_o.pad   = (chunk_left_d == '0);
    entry_o.mend  = (bytes_left_d == '0);
  end

  assign push_o = accept && !drop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q  <= '0;
      multi_q       <= 1'b0;
      frame_index_q <= '0;
      chunk_left_q  <= '0;
    end else if (accept && !drop) begin
      bytes_left_q  <= bytes_left_d;
      multi_q       <= multi_d;
      frame_index_q <= frame_index_d;
      chunk_left_q  <= chunk_left_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mrf_queue.sv */
`default_nettype none

module mrf_queue
  import mrf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire mrf_entry_t  entry_i,
  output logic             push_ready_o,
  output logic             head_valid_o,
  output mrf_entry_t       head_o,
  input  wire logic        pop_i
);

  mrf_entry_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mrf_back.sv */
`default_nettype none

module mrf_back
  import mrf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  rpt_tag_i,
  input  wire logic        head_valid_i,
  input  wire mrf_entry_t  head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       report_byte_o,
  output logic             report_end_o,
  output logic             message_end_o,
  output logic             item_last_o
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(REPORT_BYTES - 1);

  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [CI_W-1:0]   ci_q, ci_d, ci_eff;
  logic              pad_q, pad_d;
  logic              valid_q;
  logic [7:0]        byte_q, byte_d;
  logic              rend_q, mend_q, last_q;
  logic              emit, closing, last;

  assign emit    = head_valid_i && (!valid_q || out_ready_i);
  assign closing = (slot_q == LAST_SLOT);
  assign ci_eff  = head_i.hdr ? ci_q : CI_DATA;

  always_comb begin
    slot_d = closing ? '0 : slot_q + SLOT_W'(1);
    ci_d   = ci_q;
    pad_d  = pad_q;
    last   = 1'b0;
    byte_d = 8'h00;
    if (pad_q) begin
      if (closing) begin
        last  = 1'b1;
        pad_d = 1'b0;
        ci_d  = '0;
      end
    end else if (slot_q == '0) begin
      // Every report opens with the id before any content byte.
      byte_d = rpt_tag_i;
    end else begin
      byte_d = content_byte(ci_eff, head_i);
      if (ci_eff != CI_DATA) begin
        ci_d = ci_q + CI_W'(1);
      end else if (head_i.pad && !closing) begin
        pad_d = 1'b1;
      end else begin
        last = 1'b1;
        ci_d = '0;
      end
    end
  end

  assign pop_o = emit && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      ci_q    <= '0;
      pad_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      if (emit) begin
        slot_q <= slot_d;
        ci_q   <= ci_d;
        pad_q  <= pad_d;
      end
      if (emit) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q <= byte_d;
      rend_q <= closing;
      mend_q <= last && head_i.mend;
      last_q <= last;
    end
  end

  assign out_valid_o   = valid_q;
  assign report_byte_o = byte_q;
  assign report_end_o  = rend_q;
  assign message_end_o = mend_q;
  assign item_last_o   = last_q;

endmodule

`default_nettype wire

/* rtl/core/message_report_framer.sv */
// Message report framer.
// Input stream (s_axis_*): one message byte per beat; the message length rides
// along and is sampled only on a message's first byte. A first byte with length
// zero is taken and dropped.
// Output stream (m_axis_*): one report byte per beat. tlast marks the byte that
// closes a 20-byte report; tuser carries the message-end and per-input-last flags.
// Configuration (cfg_*): index 0 writes chunk_limit, index 1 writes the report id.
// cfg_ready_o is always high; write only while the block is idle.
// Throughput: the output side emits one byte per cycle while the receiver is
// ready. An input byte expands into 1 to 20 output bytes (report ids, a 14-byte
// frame header at a frame's start, zero padding at its end), so the input is
// taken as fast as the emitter drains them through a two-entry queue. An input
// beat is registered in the queue and again in the output register.
// Reset clears all framing state and restores chunk_limit 248 and report id 0x0E.
// When the receiver stalls, the output register holds its beat, the emitter
// waits, the queue fills and s_axis_tready drops; nothing is lost.
`default_nettype none

module message_report_framer
  import mrf_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [23:0]          s_axis_tdata,  // message_byte, message_length
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [7:0]                m_axis_tdata,  // report_byte
  output logic                      m_axis_tlast,  // report_end
  output logic [1:0]                m_axis_tuser,  // message_end, item_last
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [LIMIT_W-1:0]   cfg_data_i
);

  logic [LIMIT_W-1:0] chunk_limit_q;
  logic [7:0]         rpt_tag_q;
  logic               push, push_ready, head_valid, pop;
  mrf_entry_t         entry, head;
  logic               message_end, item_last;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_limit_q <= CHUNK_LIMIT_RST;
      rpt_tag_q     <= RPT_TAG_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CHUNK_LIMIT: chunk_limit_q <= cfg_data_i;
        CFG_RPT_TAG:     rpt_tag_q     <= cfg_data_i[7:0];
        default:         ;
      endcase
    end
  end

  mrf_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .chunk_limit_i    (chunk_limit_q),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .message_byte_i   (s_axis_tdata[7:0]),
    .message_length_i (s_axis_tdata[23:8]),
    .push_o           (push),
    .entry_o          (entry),
    .push_ready_i     (push_ready)
  );

  mrf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .push_ready_o (push_ready),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  mrf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rpt_tag_i     (rpt_tag_q),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .report_byte_o (m_axis_tdata),
    .report_end_o  (m_axis_tlast),
    .message_end_o (message_end),
    .item_last_o   (item_last)
  );

  assign m_axis_tuser = {item_last, message_end};

endmodule

`default_nettype wire

/* sim/tb_message_report_framer.sv */
`timescale 1ns / 100ps

module tb_message_report_framer;
  import mrf_pkg::*;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_LIMIT     = 100000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int PHASE_ITEMS     = 45;
  localparam int LONG_RUN_BEATS  = 24;
  localparam logic [63:0] FRAME_MAGIC = 64'h73796E6170746963;
  // No register lives at this index; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = CFG_IDX_W'(9);

  typedef struct packed {
    logic [7:0] data;
    logic       report_end;
    logic       message_end;
    logic       item_last;
  } report_beat_t;

  class framer_scoreboard;
    logic [LIMIT_W-1:0] chunk_limit;
    logic [7:0]         rpt_tag;
    logic [LEN_W-1:0]   bytes_left;
    logic               multi_frame;
    logic [15:0]        frame_index;
    logic [LIMIT_W-1:0] chunk_left;
    int unsigned        report_slot;
    report_beat_t       report_q[$];
    int                 errors;

    function new();
      chunk_limit = CHUNK_LIMIT_RST;
      rpt_tag     = RPT_TAG_RST;
      bytes_left  = '0;
      multi_frame = 1'b0;
      frame_index = '0;
      chunk_left  = '0;
      report_slot = 0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] value);
      if (idx == CFG_CHUNK_LIMIT) chunk_limit = value;
      else if (idx == CFG_RPT_TAG) rpt_tag = value[7:0];
    endfunction

    function void emit_raw(logic [7:0] b);
      report_beat_t beat;
      beat.data        = b;
      beat.report_end  = (report_slot + 1 >= REPORT_BYTES);
      beat.message_end = 1'b0;
      beat.item_last   = 1'b0;
      report_q.push_back(beat);
      report_slot = beat.report_end ? 0 : report_slot + 1;
    endfunction

    function void emit_content(logic [7:0] b);
      if (report_slot == 0) emit_raw(rpt_tag);
      emit_raw(b);
    endfunction

    // Works out every report byte that one accepted message byte causes.
    function void note_message_byte(logic [7:0] b, logic [LEN_W-1:0] len);
      int unsigned  limit;
      int unsigned  chunk;
      int unsigned  total;
      logic [15:0]  code;
      report_beat_t tail;
      limit = (chunk_limit == 0) ? 1 : chunk_limit;
      if (bytes_left == 0) begin
        if (len == 0) return;
        bytes_left  = len;
        multi_frame = (len > limit);
        frame_index = '0;
        chunk_left  = '0;
      end
      if (chunk_left == 0) begin
        chunk = (bytes_left < limit) ? bytes_left : limit;
        total = chunk + 2;
        if (!multi_frame) code = CODE_SINGLE;
        else if (frame_index == 0) code = CODE_FIRST;
        else if (chunk >= bytes_left) code = CODE_LAST;
        else code = frame_index;
        for (int i = 0; i < 8; i++) emit_content(FRAME_MAGIC[63 - 8*i -: 8]);
        for (int i = 0; i < 4; i++) emit_content(8'(total >> (8*i)));
        emit_content(code[7:0]);
        emit_content(code[15:8]);
        chunk_left  = LIMIT_W'(chunk);
        frame_index = frame_index + 16'd1;
      end
      emit_content(b);
      chunk_left = chunk_left - LIMIT_W'(1);
      bytes_left = bytes_left - LEN_W'(1);
      if (chunk_left == 0) begin
        while (report_slot != 0) emit_raw(8'h00);
      end
      tail = report_q.pop_back();
      tail.message_end = (bytes_left == 0);
      tail.item_last   = 1'b1;
      report_q.push_back(tail);
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s is %02h, expected %02h", name, got, want));
    endtask

    task check_report_beat(report_beat_t got);
      report_beat_t want;
      if (report_q.size() == 0) begin
        report_mismatch($sformatf("report byte %02h with nothing expected", got.data));
        return;
      end
      want = report_q.pop_front();
      compare_field("report_byte", got.data, want.data);
      compare_field("report_end", 8'(got.report_end), 8'(want.report_end));
      compare_field("message_end", 8'(got.message_end), 8'(want.message_end));
      compare_field("item_last", 8'(got.item_last), 8'(want.item_last));
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;
  logic                 m_axis_tlast;
  logic [1:0]           m_axis_tuser;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [LIMIT_W-1:0]   cfg_data_i = '0;

  int  idle_pct = 0;
  int  stall_pct = 0;
  int  hold_left = 0;
  bit  hold_req = 1'b0;

  framer_scoreboard sb = new();

  message_report_framer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Output side: checks each beat and decides readiness for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_report_beat({m_axis_tdata, m_axis_tlast, m_axis_tuser[0], m_axis_tuser[1]});
    if (hold_req) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic [LEN_W-1:0] len);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {len, b};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_message_byte(b, len);
  endtask

  // The length field is only meaningful on the first beat; later beats carry noise.
  task automatic send_message(input logic [LEN_W-1:0] len, input int beats);
    for (int i = 0; i < beats; i++)
      send_beat(8'($urandom_range(255)), (i == 0) ? len : LEN_W'($urandom_range(65535)));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, value);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stops offering input and waits until every expected report byte is out.
  task automatic wait_idle();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (sb.report_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (sb.report_q.size() != 0) begin
      sb.report_mismatch($sformatf("%0d report bytes never arrived", sb.report_q.size()));
      sb.report_q.delete();
    end
    // A dropped zero-length beat may still be in flight.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure_random();
    logic [LIMIT_W-1:0] limit;
    case ($urandom_range(7))
      0:       limit = '0;
      1:       limit = LIMIT_W'(1);
      2:       limit = '1;
      3:       limit = CHUNK_LIMIT_RST;
      default: limit = LIMIT_W'($urandom_range(2, 40));
    endcase
    write_reg(CFG_CHUNK_LIMIT, limit);
    write_reg(CFG_RPT_TAG, LIMIT_W'($urandom_range(4095)));
  endtask

  task automatic run_phase(input int idle, input int stall, input bit pressure);
    int sent;
    int len;
    idle_pct  = idle;
    stall_pct = stall;
    wait_idle();
    configure_random();
    sent = 0;
    if (pressure) begin
      // The receiver holds off while a long message keeps coming, so the block
      // backs up and must stall its input; then the sender waits for a full drain.
      hold_req = 1'b1;
      send_message(LEN_W'(50), 50);
      wait_idle();
      sent += 50;
    end
    while (sent < PHASE_ITEMS) begin
      if ($urandom_range(9) == 0)
        send_beat(8'($urandom_range(255)), '0);
      len = ($urandom_range(7) == 0) ? $urandom_range(46, 120) : $urandom_range(1, 45);
      send_message(LEN_W'(len), len);
      sent += len;
      if ($urandom_range(5) == 0) begin
        wait_idle();
        configure_random();
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: one-byte message, a dropped zero-length beat, a short message.
    send_beat(8'h00, LEN_W'(1));
    send_beat(8'hFF, '0);
    send_beat(8'hFF, LEN_W'(3));
    send_beat(8'h80, '1);
    send_beat(8'h7F, '0);
    wait_idle();

    // Small limit: first, middle and last frame codes, then a message that just fits.
    write_reg(CFG_CHUNK_LIMIT, LIMIT_W'(2));
    write_reg(CFG_RPT_TAG, '1);
    send_beat(8'hFF, LEN_W'(5));
    send_beat(8'h00, '0);
    send_beat(8'hAA, LEN_W'(1));
    send_beat(8'h55, '1);
    send_beat(8'h01, LEN_W'(7));
    send_beat(8'h80, LEN_W'(2));
    send_beat(8'h7F, '1);
    wait_idle();

    // A limit of zero behaves as one.
    write_reg(CFG_CHUNK_LIMIT, '0);
    write_reg(CFG_RPT_TAG, '0);
    write_reg(CFG_UNMAPPED, '1);
    send_message(LEN_W'(3), 3);
    wait_idle();

    // Limit changed mid-message: the open frame keeps its length.
    write_reg(CFG_CHUNK_LIMIT, LIMIT_W'(2));
    send_beat(8'hC3, LEN_W'(4));
    wait_idle();
    write_reg(CFG_CHUNK_LIMIT, LIMIT_W'(1));
    send_message(LEN_W'(4), 3);

    run_phase(0, 0, 1'b1);
    run_phase(48, 0, 1'b0);
    run_phase(0, 48, 1'b0);
    run_phase(37, 37, 1'b0);

    // Largest limit and longest length: the frame length field goes above one byte.
    idle_pct  = 0;
    stall_pct = 0;
    wait_idle();
    write_reg(CFG_CHUNK_LIMIT, '1);
    write_reg(CFG_RPT_TAG, LIMIT_W'($urandom_range(4095)));
    send_message('1, LONG_RUN_BEATS);
    wait_idle();

    if (sb.errors == 0)
      $display("message_report_framer regression: pass");
    else
      $display("message_report_framer regression: fail");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("message_report_framer regression: fail");
    $finish;
  end

endmodule
